### rtl/quadrature_encoder_with_click_top_defines.svh
// Assertion macros used by the encoder core RTL file.
`ifndef QUADRATURE_ENCODER_WITH_CLICK_TOP_DEFINES_SVH
`define QUADRATURE_ENCODER_WITH_CLICK_TOP_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define QEC_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("qec: same-cycle check failed");

// The condition holds in the cycle after the trigger.
`define QEC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("qec: next-cycle check failed");

`endif

### rtl/qec_pkg.sv
// Shared types and constants for the quadrature encoder with click detection.
package qec_pkg;

    localparam logic [1:0] MODE_TICK       = 2'd0;
    localparam logic [1:0] MODE_READ_DELTA = 2'd1;
    localparam logic [1:0] MODE_READ_CLICK = 2'd2;

    localparam logic [15:0] HOLDOFF_RESET = 16'd50;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] pin_levels;
    } item_t;

endpackage

### rtl/qec_in_stage.sv
// Input register taking one request per cycle when empty or being emptied.
module qec_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  qec_pkg::item_t in_item,
    output logic          item_valid,
    output qec_pkg::item_t item,
    input  logic          item_take
);
    import qec_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/qec_core.sv
// Encoder state, click detection and the result register.
`include "quadrature_encoder_with_click_top_defines.svh"

module qec_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  logic               item_valid,
    input  qec_pkg::item_t     item,
    output logic               item_take,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [6:0]  step_delta,
    output logic               click_taken,
    output logic               button_held
);
    import qec_pkg::*;

    logic [15:0] holdoff_reg;
    logic [1:0]  last_pos_reg;
    logic [1:0]  last_pos_next;
    logic [7:0]  delta_reg;
    logic [7:0]  delta_next;
    logic        press_reg;
    logic        press_next;
    logic        pending_reg;
    logic        pending_next;
    logic [15:0] timer_reg;
    logic [15:0] timer_next;
    logic [15:0] timer_inc;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [6:0]  delta_out_reg;
    logic [6:0]  delta_out_next;
    logic        click_out_reg;
    logic        click_out_next;
    logic        held_reg;

    logic        pressed;
    logic [1:0]  pos;
    logic [1:0]  diff;

    assign item_take = item_valid && (!out_valid_reg || out_ready);

    // Active-low pins: phase two low gives position 3, phase one low flips bit 0.
    assign pressed   = !item.pin_levels[2];
    assign pos       = {!item.pin_levels[1], item.pin_levels[1] ^ item.pin_levels[0]};
    assign diff      = last_pos_reg - pos;
    assign timer_inc = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 16'd1;

    always_comb
    begin
        last_pos_next  = last_pos_reg;
        delta_next     = delta_reg;
        press_next     = press_reg;
        pending_next   = pending_reg;
        timer_next     = timer_reg;
        delta_out_next = 7'd0;
        click_out_next = 1'b0;
        if (item_take)
        begin
            unique case (item.mode)
                MODE_TICK:
                begin
                    if (diff[0])
                    begin
                        last_pos_next = pos;
                        delta_next    = diff[1] ? delta_reg + 8'd1 : delta_reg - 8'd1;
                    end
                    timer_next = timer_inc;
                    if (!pending_reg && (timer_inc > holdoff_reg))
                    begin
                        if (pressed)
                        begin
                            press_next = 1'b1;
                        end
                        else if (press_reg)
                        begin
                            press_next   = 1'b0;
                            pending_next = 1'b1;
                        end
                    end
                end
                MODE_READ_DELTA:
                begin
                    delta_out_next = delta_reg[7:1];
                    delta_next     = {7'd0, delta_reg[0]};
                end
                MODE_READ_CLICK:
                begin
                    if (pending_reg)
                    begin
                        click_out_next = 1'b1;
                        pending_next   = 1'b0;
                        timer_next     = 16'd0;
                    end
                end
                default:
                begin
                    delta_out_next = 7'd0;
                end
            endcase
        end
    end

    assign out_valid_next = item_take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg   <= HOLDOFF_RESET;
            last_pos_reg  <= 2'd0;
            delta_reg     <= 8'd0;
            press_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            timer_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                holdoff_reg <= cfg_data;
            end
            last_pos_reg  <= last_pos_next;
            delta_reg     <= delta_next;
            press_reg     <= press_next;
            pending_reg   <= pending_next;
            timer_reg     <= timer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            delta_out_reg <= delta_out_next;
            click_out_reg <= click_out_next;
            held_reg      <= pressed;
        end
    end

    assign out_valid   = out_valid_reg;
    assign step_delta  = delta_out_reg;
    assign click_taken = click_out_reg;
    assign button_held = held_reg;

    `QEC_ASSERT_SAME(a_pending_clears_press, pending_reg, !press_reg)
    `QEC_ASSERT_SAME(a_one_result_kind, out_valid_reg && click_out_reg, delta_out_reg == 7'd0)
    `QEC_ASSERT_NEXT(a_delta_read_clears, item_take && (item.mode == MODE_READ_DELTA), delta_reg[7:1] == 7'd0)
    `QEC_ASSERT_NEXT(a_timer_counts, item_take && (item.mode == MODE_TICK) && (timer_reg != TIMER_MAX), timer_reg == $past(timer_reg) + 16'd1)

endmodule

### rtl/quadrature_encoder_with_click_top.sv
// Top level of the quadrature encoder interface with push-button click detection.
//
// Every request carries a mode and a sample of the active-low encoder pins. A tick
// request decodes the two phases from Gray code to a position, adds one step up or
// down to a wrapping 8-bit count, advances the hold-off timer and watches the button
// for a press followed by a release. A read-delta request returns the count shifted
// right by one (a double-step encoder) and keeps only the odd bit; a read-click
// request returns and clears the pending click and restarts the hold-off timer.
// Every request gives exactly one result, and button_held always reflects the sampled
// button pin. The block takes one request per clock cycle while the input register is
// free or its request goes on to the core; an accepted request passes through the input
// register, then the decode and state update, then the result register. The result
// register frees the input side, so a new request is taken while a finished result
// waits, as long as the result is taken in the same cycle or the pipeline still has a
// free slot. The hold-off register resets to 50 ticks; the user must write it through
// cfg_we and cfg_data only while no request is in flight, which the block never checks.
module quadrature_encoder_with_click_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [2:0]        pin_levels,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [6:0] step_delta,
    output logic              click_taken,
    output logic              button_held
);
    import qec_pkg::*;

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  item_take;

    assign in_item.mode       = mode;
    assign in_item.pin_levels = pin_levels;

    // Input register: holds the accepted request until the core takes it.
    qec_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Core: decodes the request, updates the encoder state and registers the result.
    qec_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .step_delta  (step_delta),
        .click_taken (click_taken),
        .button_held (button_held)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for the quadrature encoder block with push-button click detection.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qec_pkg::*;

    // The package names the three real modes; the fourth code must leave the state untouched.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Styles of idling that each side draws its per-request wait from.
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_RANDOM = 1;
    localparam int IDLE_BURSTY = 2;

    // Length of the deliberate receiver hold-off that backs up the pipeline.
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic signed [6:0] step_delta;
        logic              click_taken;
        logic              button_held;
    } encoder_result_t;

    // Ports of the block. Every input starts at a known value.
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [15:0]       cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [1:0]        mode        = MODE_TICK;
    logic [2:0]        pin_levels  = 3'b111;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic signed [6:0] step_delta;
    logic              click_taken;
    logic              button_held;

    quadrature_encoder_with_click_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .pin_levels  (pin_levels),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .step_delta  (step_delta),
        .click_taken (click_taken),
        .button_held (button_held)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Requests waiting to be offered, and results that the encoder model says must come back.
    item_t           pending_requests[$];
    encoder_result_t expected_results[$];

    // Our own copy of the encoder state, kept in step with every accepted request.
    logic [15:0] holdoff_setting = HOLDOFF_RESET;
    logic [1:0]  model_position  = 2'd0;
    logic [7:0]  model_steps     = 8'd0;
    logic        model_press     = 1'b0;
    logic        model_click     = 1'b0;
    logic [15:0] model_timer     = 16'd0;

    // Handshake flags: set by the monitor at the rising edge, consumed by the drivers at the
    // falling edge, so the two never touch them in the same time step.
    bit req_accepted = 1'b0;
    bit res_accepted = 1'b0;

    int tx_style = IDLE_NONE;
    int rx_style = IDLE_NONE;
    int tx_wait  = 0;
    int rx_wait  = 0;
    bit offering = 1'b0;
    bit rx_blocked    = 1'b0;
    bit long_hold_go  = 1'b0;
    item_t next_req;

    // Stimulus-side picture of the knob, so gestures are physically sensible pin sequences.
    logic [1:0] knob_pos     = 2'd0;
    bit         knob_pressed = 1'b0;

    int mismatch_count  = 0;
    int results_checked = 0;
    int requests_queued = 0;
    int ticks_seen      = 0;
    int delta_reads     = 0;
    int click_reads     = 0;
    int clicks_taken    = 0;
    int saturated_ticks = 0;
    int holdoff_writes  = 0;

    function automatic int draw_gap(input int style);
        case (style)
            IDLE_NONE:   return 0;
            IDLE_RANDOM: return $urandom_range(0, 15);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        endcase
    endfunction

    // Applies one request to the encoder model and records the result it must produce.
    task automatic advance_encoder_model(input logic [1:0] req_mode, input logic [2:0] req_pins);
        logic [1:0]      pos;
        logic [1:0]      step_dist;
        logic            pressed;
        encoder_result_t res;
        pressed         = !req_pins[2];
        res             = '0;
        res.button_held = pressed;
        case (req_mode)
            MODE_TICK:
            begin
                ticks_seen++;
                // Gray to binary: phase two low gives 3, phase one low flips the low bit.
                pos = req_pins[1] ? 2'd0 : 2'd3;
                if (!req_pins[0])
                    pos ^= 2'd1;
                // A single step in either direction moves the count; a two-step jump is
                // ambiguous and is dropped without updating the stored position.
                step_dist = model_position - pos;
                if (step_dist[0])
                begin
                    model_position = pos;
                    model_steps    = (step_dist == 2'd3) ? model_steps + 8'd1
                                                         : model_steps - 8'd1;
                end
                if (model_timer != TIMER_MAX)
                    model_timer++;
                else
                    saturated_ticks++;
                if (!model_click && model_timer > holdoff_setting)
                begin
                    if (!model_press && pressed)
                        model_press = 1'b1;
                    if (model_press && !pressed)
                    begin
                        model_press = 1'b0;
                        model_click = 1'b1;
                    end
                end
            end
            MODE_READ_DELTA:
            begin
                delta_reads++;
                // Double-step encoder: report half the count and keep the odd step.
                res.step_delta = model_steps[7:1];
                model_steps    = {7'd0, model_steps[0]};
            end
            MODE_READ_CLICK:
            begin
                click_reads++;
                if (model_click)
                begin
                    clicks_taken++;
                    res.click_taken = 1'b1;
                    model_click     = 1'b0;
                    model_timer     = 16'd0;
                end
            end
            default:
                ;
        endcase
        expected_results.push_back(res);
    endtask

    // Monitor. Outputs and handshakes are sampled at the rising edge, before the block's
    // own registers update, so sampling never depends on scheduling order.
    always @(posedge clk)
    begin
        encoder_result_t want;
        if (!rst_n)
        begin
            holdoff_setting <= HOLDOFF_RESET;
            model_position  <= 2'd0;
            model_steps     <= 8'd0;
            model_press     <= 1'b0;
            model_click     <= 1'b0;
            model_timer     <= 16'd0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                res_accepted = 1'b1;
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: step_delta %0d click %0b",
                           step_delta, click_taken);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (step_delta !== want.step_delta)
                    begin
                        $error("step_delta: expected %0d, actual %0d", want.step_delta,
                               step_delta);
                        mismatch_count++;
                    end
                    if (click_taken !== want.click_taken)
                    begin
                        $error("click_taken: expected %0b, actual %0b", want.click_taken,
                               click_taken);
                        mismatch_count++;
                    end
                    if (button_held !== want.button_held)
                    begin
                        $error("button_held: expected %0b, actual %0b", want.button_held,
                               button_held);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we)
                holdoff_setting = cfg_data;
            if (in_valid && in_ready)
            begin
                req_accepted = 1'b1;
                advance_encoder_model(mode, pin_levels);
            end
        end
    end

    // Request driver. Holds each request steady until it is taken, then waits the drawn
    // number of cycles before offering the next one.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (req_accepted)
            begin
                req_accepted = 1'b0;
                offering     = 1'b0;
                tx_wait      = draw_gap(tx_style);
            end
            if (!offering)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req   = pending_requests.pop_front();
                    mode       <= next_req.mode;
                    pin_levels <= next_req.pin_levels;
                    in_valid   <= 1'b1;
                    offering   = 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result-side ready. After each result the receiver stalls for a drawn number of cycles
    // while a result is on offer; the long hold-off overrides it entirely.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (res_accepted)
            begin
                res_accepted = 1'b0;
                rx_wait      = draw_gap(rx_style);
            end
            else if (rx_wait > 0 && out_valid && !rx_blocked)
                rx_wait--;
            out_ready <= !rx_blocked && rx_wait == 0;
        end
    end

    // Long receiver hold-off: the sender keeps going, so the block fills and drops in_ready.
    initial
    begin
        wait (long_hold_go);
        @(posedge clk);
        rx_blocked <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rx_blocked <= 1'b0;
    end

    function automatic logic [1:0] phase_pattern(input logic [1:0] pos);
        case (pos)
            2'd0:    return 2'b11;
            2'd1:    return 2'b10;
            2'd2:    return 2'b00;
            default: return 2'b01;
        endcase
    endfunction

    task automatic queue_request(input logic [1:0] req_mode, input logic [2:0] req_pins);
        item_t r;
        r.mode       = req_mode;
        r.pin_levels = req_pins;
        pending_requests.push_back(r);
        requests_queued++;
    endtask

    task automatic queue_tick();
        queue_request(MODE_TICK, {!knob_pressed, phase_pattern(knob_pos)});
    endtask

    task automatic turn_knob(input bit up);
        knob_pos = up ? knob_pos + 2'd1 : knob_pos - 2'd1;
    endtask

    // Continuous rotation in one direction, long enough to wrap the 8-bit step count.
    task automatic queue_spin();
        bit up;
        up = $urandom_range(0, 1);
        repeat ($urandom_range(260, 300))
        begin
            turn_knob(up);
            queue_tick();
        end
    endtask

    // One user gesture: mostly clean turns, presses and reads, with a little line noise.
    task automatic queue_gesture();
        int pick;
        bit up;
        pick = $urandom_range(0, 99);
        up   = $urandom_range(0, 1);
        if (pick < 40)
        begin
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // Contact bounce: a step forward and back before the real step.
                    turn_knob(up);
                    queue_tick();
                    turn_knob(!up);
                    queue_tick();
                end
                if ($urandom_range(0, 15) == 0)
                    turn_knob(up);
                turn_knob(up);
                queue_tick();
            end
        end
        else if (pick < 41)
            queue_spin();
        else if (pick < 63)
        begin
            knob_pressed = 1'b1;
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 3) == 0)
                    turn_knob(up);
                queue_tick();
            end
            knob_pressed = 1'b0;
            queue_tick();
        end
        else if (pick < 73)
            repeat ($urandom_range(1, 10)) queue_tick();
        else if (pick < 84)
            queue_request(MODE_READ_DELTA, 3'($urandom_range(0, 7)));
        else if (pick < 95)
            queue_request(MODE_READ_CLICK, 3'($urandom_range(0, 7)));
        else
            queue_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    endtask

    // Waits until nothing is queued, offered or outstanding, then lets the pipeline drain.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_holdoff(input logic [15:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        holdoff_writes++;
        @(posedge clk);
    endtask

    task automatic random_phase(input logic [15:0] holdoff, input int tx, input int rx,
                                input int count);
        int start;
        wait_idle();
        write_holdoff(holdoff);
        tx_style = tx;
        rx_style = rx;
        start    = requests_queued;
        while (requests_queued - start < count)
            queue_gesture();
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks at the reset hold-off of 50 ticks: the unused mode, reads of an
        // empty count and of no pending click, a full turn up, one step back, and a
        // two-position jump that must be ignored.
        queue_request(MODE_UNUSED, 3'b000);
        queue_request(MODE_READ_DELTA, 3'b111);
        queue_request(MODE_READ_CLICK, 3'b111);
        queue_request(MODE_TICK, 3'b111);
        queue_request(MODE_TICK, 3'b110);
        queue_request(MODE_TICK, 3'b100);
        queue_request(MODE_TICK, 3'b101);
        queue_request(MODE_TICK, 3'b111);
        queue_request(MODE_TICK, 3'b101);
        queue_request(MODE_TICK, 3'b110);
        queue_request(MODE_READ_DELTA, 3'b000);

        // With no hold-off a press and release give a click at once. A press while a click
        // is pending is ignored, and a second read after taking the click returns zero.
        wait_idle();
        write_holdoff(16'd0);
        queue_request(MODE_TICK, 3'b011);
        queue_request(MODE_TICK, 3'b111);
        queue_request(MODE_TICK, 3'b011);
        queue_request(MODE_READ_CLICK, 3'b111);
        queue_request(MODE_READ_CLICK, 3'b010);
        queue_request(MODE_TICK, 3'b011);
        queue_request(MODE_TICK, 3'b111);
        queue_request(MODE_UNUSED, 3'b111);
        queue_request(MODE_READ_CLICK, 3'b111);
        queue_request(MODE_READ_DELTA, 3'b000);

        knob_pos     = 2'd0;
        knob_pressed = 1'b0;

        random_phase(16'd0, IDLE_RANDOM, IDLE_RANDOM, 200);
        random_phase(16'd3, IDLE_NONE, IDLE_NONE, 200);
        queue_spin();

        // Back-pressure phase: the sender never idles while the receiver holds off.
        random_phase(16'd2, IDLE_NONE, IDLE_BURSTY, 200);
        long_hold_go = 1'b1;

        random_phase(HOLDOFF_RESET, IDLE_RANDOM, IDLE_BURSTY, 200);
        random_phase(16'($urandom_range(0, 20)), IDLE_BURSTY, IDLE_BURSTY, 200);
        // The largest hold-off can never be passed, so no new click can be registered here.
        random_phase(TIMER_MAX, IDLE_RANDOM, IDLE_RANDOM, 200);
        random_phase(16'($urandom), IDLE_RANDOM, IDLE_NONE, 150);
        random_phase(16'd7, IDLE_RANDOM, IDLE_RANDOM, 200);

        wait_idle();
        repeat (10) @(posedge clk);

        $display("Checked %0d results from %0d requests under %0d hold-off settings.",
                 results_checked, requests_queued, holdoff_writes + 1);
        $display("Ticks %0d, delta reads %0d, click reads %0d, clicks %0d, saturated ticks %0d.",
                 ticks_seen, delta_reads, click_reads, clicks_taken, saturated_ticks);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: several times the slowest legal run with the longest idle draws.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding.", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/qec_pkg.sv
rtl/qec_in_stage.sv
rtl/qec_core.sv
rtl/quadrature_encoder_with_click_top.sv
tb/tb.sv
